@@ rtl/assert_macros.svh @@
// Assertion macros shared by the page allocator RTL.
// No dependencies; each file that checks its own logic includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property with asynchronous active-low reset disable.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

@@ rtl/bcpa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the bitmap page allocator.
// No dependencies; imported by the controller, datapath and top level.
package bcpa_pkg;

	localparam int ADDR_W     = 48;
	localparam int COUNT_W    = 15;
	localparam int STATUS_W   = 2;
	localparam int IN_TDATA_W = 64;   // page_count + address, padded to bytes
	localparam int OUT_TDATA_W = 48;

	// map words and the chunks a scan step walks through
	localparam int WORD_BITS = 64;
	localparam int WORD_LOG  = 6;
	localparam int CHUNK_BITS = 8;
	localparam int CHUNK_LOG  = 3;

	localparam logic OP_RESERVE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOSPACE   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_DOUBLEFREE = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_OUTSIDE   = 2'd3;

	typedef struct packed {
		logic take;      // capture request word
		logic check;     // decode request, set up range
		logic rd;        // read map word at word pointer
		logic step;      // scan one chunk of the read word
		logic mk_wr;     // write back marked/cleared word
		logic clr_wr;    // reset clearing pass write
		logic load_out;  // load result register
	} cmd_t;

	typedef struct packed {
		logic skip;        // request finishes at decode
		logic is_rel;
		logic found;
		logic chunk_last;
		logic word_last;
		logic mk_last;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/bitmap_contiguous_page_allocator_core.sv @@
`timescale 1ns / 1ps
// Top level of the first-fit bitmap page allocator.
// Depends on bcpa_pkg, bcpa_ram, bcpa_ctrl and bcpa_dp.

// The usage map is held one bit per page in a RAM of 64-bit words and is walked
// by a sequencer one word at a time; one request is worked on at a time and
// gives one result word. After reset a clearing pass writes every map word to
// free, all MAP_WORDS words (256 at the default 16384 pages), and no request
// is taken until it ends. A reserve scans the map word by word, one RAM read and
// eight chunks of eight pages per word, up to the end of the first fitting run,
// then reads and writes back each word the run touches; a failed reserve scans
// all MAP_WORDS words. A release does one read and one write-back per word it
// touches; an invalid request finishes at decode. The result register lets the
// next request start while the last result waits. area_base may be written
// whenever no request is busy.
module bitmap_contiguous_page_allocator_core #(
	parameter int NUM_PAGES = 16384,
	parameter int PAGE_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [bcpa_pkg::IN_TDATA_W-1:0]     s_tdata,   // page_count[14:0], address[62:15], 0
	input  logic                                s_tuser,   // operation
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bcpa_pkg::OUT_TDATA_W-1:0]    m_tdata,   // result_address[47:0]
	output logic [bcpa_pkg::STATUS_W-1:0]       m_tuser,   // status[1:0]
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bcpa_pkg::ADDR_W-1:0]         cfg_data   // area_base
);

	import bcpa_pkg::*;

	localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	cmd_t  cmd;
	stat_t st;

	logic                 ram_we, ram_re;
	logic [WADDR_W-1:0]   ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;

	bcpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	bcpa_dp #(
		.NUM_PAGES (NUM_PAGES),
		.PAGE_BITS (PAGE_BITS),
		.MAP_WORDS (MAP_WORDS),
		.WADDR_W   (WADDR_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	bcpa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

@@ rtl/bcpa_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bcpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/bcpa_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the page allocator: clearing pass, scan, mark and result hand-off.
// Depends on bcpa_pkg.
module bcpa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  bcpa_pkg::stat_t st,
	output bcpa_pkg::cmd_t  cmd
);

	import bcpa_pkg::*;

	localparam logic [2:0] S_CLR    = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_CHK    = 3'd2;
	localparam logic [2:0] S_SC_RD  = 3'd3;
	localparam logic [2:0] S_SC_RUN = 3'd4;
	localparam logic [2:0] S_MK_RD  = 3'd5;
	localparam logic [2:0] S_MK_WR  = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0] state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (st.word_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				cmd.check = 1'b1;
				priority if (st.skip) state_d = S_DONE;
				else if (st.is_rel)   state_d = S_MK_RD;
				else                  state_d = S_SC_RD;
			end
			S_SC_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_SC_RUN;
			end
			S_SC_RUN: begin
				cmd.step = 1'b1;
				priority if (st.found)                    state_d = S_MK_RD;
				else if (st.chunk_last && st.word_last)   state_d = S_DONE;
				else if (st.chunk_last)                   state_d = S_SC_RD;
			end
			S_MK_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_MK_WR;
			end
			S_MK_WR: begin
				cmd.mk_wr = 1'b1;
				state_d   = st.mk_last ? S_DONE : S_MK_RD;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/bcpa_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the page allocator: request registers, word pointer, run tracking,
// word masks, result register. Depends on bcpa_pkg and assert_macros.svh.
module bcpa_dp #(
	parameter int NUM_PAGES = 16384,
	parameter int PAGE_BITS = 12,
	parameter int MAP_WORDS = (NUM_PAGES + 63) / 64,
	parameter int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bcpa_pkg::cmd_t                      cmd,
	output bcpa_pkg::stat_t                     st,
	input  logic [bcpa_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                s_tuser,
	input  logic                                cfg_valid,
	input  logic [bcpa_pkg::ADDR_W-1:0]         cfg_data,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [bcpa_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic [bcpa_pkg::STATUS_W-1:0]       m_tuser,
	output logic                                ram_we,
	output logic [WADDR_W-1:0]                  ram_waddr,
	output logic [bcpa_pkg::WORD_BITS-1:0]      ram_wdata,
	output logic                                ram_re,
	output logic [WADDR_W-1:0]                  ram_raddr,
	input  logic [bcpa_pkg::WORD_BITS-1:0]      ram_rdata
);

	import bcpa_pkg::*;

	`include "assert_macros.svh"

	// page index width: holds any page of the map plus a full count
	localparam int IDX_W = ((WADDR_W + WORD_LOG > COUNT_W) ? WADDR_W + WORD_LOG : COUNT_W) + 1;
	localparam int PIDX_W = ADDR_W - PAGE_BITS;
	localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(MAP_WORDS - 1);
	localparam logic [IDX_W-1:0] NPAGES = IDX_W'(NUM_PAGES);

	logic                  op_q;
	logic [COUNT_W-1:0]    cnt_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [ADDR_W-1:0]     area_base_q;
	logic [WADDR_W-1:0]    w_q;
	logic [CHUNK_LOG-1:0]  k_q;
	logic [IDX_W-1:0]      start_q, end_q;
	logic [COUNT_W-1:0]    run_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [STATUS_W-1:0]   m_tuser_q;

	// request decode
	logic [ADDR_W:0]       diff;
	logic [PIDX_W-1:0]     pidx;
	logic                  outside;
	logic                  rsv_bad;
	logic [IDX_W-1:0]      end_sum;
	logic [IDX_W-1:0]      end_last;

	assign diff    = {1'b0, addr_q} - {1'b0, area_base_q};
	assign pidx    = diff[ADDR_W-1:PAGE_BITS];
	assign outside = diff[ADDR_W] | (pidx >= PIDX_W'(NUM_PAGES));
	assign rsv_bad = (cnt_q == '0) || (IDX_W'(cnt_q) > NPAGES);
	assign end_sum = start_q + IDX_W'(cnt_q);
	assign end_last = end_q - IDX_W'(1);

	// scan of one chunk of eight pages
	logic [IDX_W-1:0]   step_start;
	logic [COUNT_W-1:0] step_run;
	logic               step_found;

	always_comb begin
		logic [IDX_W-1:0]     p;
		logic [CHUNK_LOG-1:0] jv;
		logic                 used;
		step_start = start_q;
		step_run   = run_q;
		step_found = 1'b0;
		for (int j = 0; j < CHUNK_BITS; j++) begin
			jv   = CHUNK_LOG'(j);
			p    = IDX_W'({w_q, k_q, jv});
			used = ram_rdata[{k_q, jv}] | (p >= NPAGES);
			if (!step_found) begin
				if (used) begin
					step_start = p + IDX_W'(1);
					step_run   = '0;
				end else begin
					step_run = step_run + COUNT_W'(1);
					if (step_run == cnt_q) step_found = 1'b1;
				end
			end
		end
	end

	// bits of the current word that fall in [start, end)
	logic [WORD_BITS-1:0] mask_c;
	logic [WORD_BITS-1:0] new_word;

	always_comb begin
		logic [IDX_W-1:0] p;
		for (int b = 0; b < WORD_BITS; b++) begin
			p         = IDX_W'({w_q, WORD_LOG'(b)});
			mask_c[b] = (p >= start_q) && (p < end_q);
		end
	end

	assign new_word = (op_q == OP_RELEASE) ? (ram_rdata & ~mask_c) : (ram_rdata | mask_c);

	assign ram_we    = cmd.clr_wr | cmd.mk_wr;
	assign ram_waddr = w_q;
	assign ram_wdata = cmd.clr_wr ? '0 : new_word;
	assign ram_re    = cmd.rd;
	assign ram_raddr = w_q;

	always_comb begin
		st            = '0;
		st.skip       = (op_q == OP_RESERVE) ? rsv_bad : (outside || (cnt_q == '0));
		st.is_rel     = (op_q == OP_RELEASE);
		st.found      = step_found;
		st.chunk_last = (k_q == '1);
		st.word_last  = (w_q == LAST_WORD);
		st.mk_last    = (w_q == end_last[WADDR_W+WORD_LOG-1:WORD_LOG]);
		st.out_free   = !m_tvalid_q || m_tready;
	end

	// end of range, clamped to the map, settles in the cycle after start_q; request capture, result load
	always_ff @(posedge clk) begin
		end_q <= (end_sum > NPAGES) ? NPAGES : end_sum;
		if (cmd.take) begin
			op_q   <= s_tuser;
			cnt_q  <= s_tdata[COUNT_W-1:0];
			addr_q <= s_tdata[COUNT_W+ADDR_W-1:COUNT_W];
		end
		if (cmd.load_out) begin
			m_tdata_q <= (op_q == OP_RESERVE && status_q == STAT_OK)
				? area_base_q + (ADDR_W'(start_q) << PAGE_BITS) : '0;
			m_tuser_q <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_base_q <= '0;
			w_q         <= '0;
			k_q         <= '0;
			start_q     <= '0;
			run_q       <= '0;
			status_q    <= STAT_OK;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_valid) area_base_q <= cfg_data;

			if (cmd.clr_wr) begin
				w_q <= (w_q == LAST_WORD) ? '0 : w_q + WADDR_W'(1);
			end

			if (cmd.check) begin
				run_q <= '0;
				if (op_q == OP_RESERVE) begin
					start_q  <= '0;
					w_q      <= '0;
					status_q <= STAT_NOSPACE;
				end else begin
					start_q  <= IDX_W'(pidx);
					w_q      <= pidx[WADDR_W+WORD_LOG-1:WORD_LOG];
					status_q <= outside ? STAT_OUTSIDE : STAT_OK;
				end
			end

			if (cmd.rd) k_q <= '0;

			if (cmd.step) begin
				start_q <= step_start;
				run_q   <= step_run;
				if (step_found) begin
					w_q      <= step_start[WADDR_W+WORD_LOG-1:WORD_LOG];
					status_q <= STAT_OK;
				end else begin
					k_q <= k_q + CHUNK_LOG'(1);
					if (k_q == '1 && w_q != LAST_WORD) w_q <= w_q + WADDR_W'(1);
				end
			end

			if (cmd.mk_wr) begin
				if (op_q == OP_RELEASE && (mask_c & ~ram_rdata) != '0) begin
					status_q <= STAT_DOUBLEFREE;
				end
				if (w_q != end_last[WADDR_W+WORD_LOG-1:WORD_LOG]) w_q <= w_q + WADDR_W'(1);
			end

			if (cmd.load_out)  m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// write-back uses the word read in the cycle before
	`ASSERT_PROP(a_wr_after_rd, clk, arst_n, cmd.mk_wr |-> $past(cmd.rd), "map write without read")
	// a reserve never claims a page that is already used
	`ASSERT_NEVER(a_rsv_overlap, clk, arst_n, cmd.mk_wr && op_q == OP_RESERVE && (mask_c & ram_rdata) != '0, "reserve marks used page")
	// result register is never overwritten while a word waits
	`ASSERT_PROP(a_out_free, clk, arst_n, cmd.load_out |-> (!m_tvalid_q || m_tready), "result overwritten")

endmodule
